/* design/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants, types and helpers for the EMA relative strength index.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int PRICE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int AVG_BITS_MAX      = 62;

    // The weight and the result are both unsigned Q16 with one integer bit.
    localparam int Q_BITS      = 16;
    localparam int WEIGHT_W    = 17;
    localparam int LEVEL_W     = 17;
    localparam int OUT_TDATA_W = 24;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd8738;

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH = 2;

    typedef struct packed {
        logic seed;   // second item of a series: load the averages directly
        logic up;     // the price rose against the previous one
    } t_cmd_flags;

    localparam int FLAGS_W = $bits(t_cmd_flags);

    // Width of the averages: integer plus fraction bits, capped.
    function automatic int avg_width(input int price_bits, input int fraction_bits);
        int w;
        w = price_bits + fraction_bits;
        return (w > AVG_BITS_MAX) ? AVG_BITS_MAX : w;
    endfunction

endpackage

/* design/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front
// Accepts prices, tracks the series position and the previous price, and
// turns each price after the first of a series into a fixed-point command.
// ----------------------------------------------------------------------------
module rsi_front #(
    parameter int PRICE_BITS    = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF,
    parameter int AVG_BITS      = rsi_pkg::avg_width(PRICE_BITS, FRACTION_BITS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PRICE_BITS-1:0] i_price,
    input  logic                  i_start,
    input  logic                  i_full,
    output logic                  o_push,
    output rsi_pkg::t_cmd_flags   o_flags,
    output logic [AVG_BITS-1:0]   o_mag
);

    localparam int WIDE_W = PRICE_BITS + FRACTION_BITS;

    typedef enum logic [1:0] {
        POS_EMPTY,
        POS_ONE,
        POS_SEEDED
    } t_pos;

    t_pos                  r_pos;
    logic [PRICE_BITS-1:0] r_prev;

    logic                  accept;
    logic                  first;
    logic                  up;
    logic [PRICE_BITS-1:0] diff;
    logic [WIDE_W-1:0]     wide;
    logic                  sat;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign first   = i_start || (r_pos == POS_EMPTY);

    assign up   = i_price > r_prev;
    assign diff = up ? (i_price - r_prev) : (r_prev - i_price);
    assign wide = {diff, {FRACTION_BITS{1'b0}}};
    // Only when the average width is capped can the scaled difference overflow.
    assign sat  = (wide >> AVG_BITS) != '0;

    assign o_push       = accept && !first;
    assign o_flags.seed = (r_pos == POS_ONE);
    assign o_flags.up   = up;
    assign o_mag        = sat ? {AVG_BITS{1'b1}} : wide[AVG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_EMPTY;
        end else if (accept) begin
            r_pos <= first ? POS_ONE : POS_SEEDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev <= i_price;
        end
    end

    a_pos_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pos == POS_ONE || r_pos == POS_SEEDED))
        else $error("series position empty after an accepted price");

endmodule

/* design/rsi_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// rsi_cmd_fifo
// Short command queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module rsi_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rsi_pkg::CMD_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("word pushed into a full command queue");

endmodule

/* design/rsi_back.sv */
// ----------------------------------------------------------------------------
// rsi_back
// Seeds the rise and fall averages or updates them with a shared chunked
// multiplier, then forms rise/(rise+fall) by restoring division and holds it.
// ----------------------------------------------------------------------------
module rsi_back #(
    parameter int AVG_BITS = rsi_pkg::avg_width(rsi_pkg::PRICE_BITS_DEF,
                                                rsi_pkg::FRACTION_BITS_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rsi_pkg::WEIGHT_W-1:0]   i_weight,
    input  logic                           i_cmd_valid,
    input  rsi_pkg::t_cmd_flags            i_cmd_flags,
    input  logic [AVG_BITS-1:0]            i_cmd_mag,
    output logic                           o_cmd_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rsi_pkg::LEVEL_W-1:0]    o_level
);

    localparam int Q       = rsi_pkg::Q_BITS;
    localparam int WW      = rsi_pkg::WEIGHT_W;
    localparam int NCHUNK  = (AVG_BITS + Q - 1) / Q;
    localparam int PAD_W   = NCHUNK * Q;
    localparam int PROD_W  = PAD_W + WW;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int DCNT_W  = $clog2(Q);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SEL_SAMPLE,
        SEL_SAME,
        SEL_OTHER
    } t_sel;

    t_state                      r_state;
    t_sel                        r_sel;
    logic [CHUNK_W-1:0]          r_chunk;
    logic [PROD_W-1:0]           r_acc;
    logic                        r_up;
    logic [AVG_BITS-1:0]         r_mag;
    logic [AVG_BITS-1:0]         r_rise;
    logic [AVG_BITS-1:0]         r_fall;
    logic [AVG_BITS-1:0]         r_p_sample;
    logic [AVG_BITS-1:0]         r_p_same;
    logic [AVG_BITS:0]           r_den;
    logic [AVG_BITS:0]           r_rem;
    logic [rsi_pkg::LEVEL_W-1:0] r_quot;
    logic [DCNT_W-1:0]           r_div_cnt;
    logic                        r_out_valid;
    logic [rsi_pkg::LEVEL_W-1:0] r_out_level;

    logic [WW-1:0]       w_clamp;
    logic [WW-1:0]       w_rest;
    logic [WW-1:0]       mul_b;
    logic [AVG_BITS-1:0] mul_a;
    logic [PAD_W-1:0]    a_pad;
    logic [Q-1:0]        chunk;
    logic [Q+WW-1:0]     part;
    logic [PROD_W-1:0]   n_acc;
    logic [AVG_BITS-1:0] mul_res;
    logic                last_chunk;
    logic [AVG_BITS:0]   sum;
    logic [AVG_BITS:0]   den;
    logic [AVG_BITS+1:0] rem2;
    logic                ge;
    logic [AVG_BITS+1:0] rem_sub;

    // A weight above one acts as exactly one.
    assign w_clamp = (i_weight > rsi_pkg::WEIGHT_ONE) ? rsi_pkg::WEIGHT_ONE : i_weight;
    assign w_rest  = rsi_pkg::WEIGHT_ONE - w_clamp;

    always_comb begin
        case (r_sel)
            SEL_SAMPLE: mul_a = r_mag;
            SEL_SAME:   mul_a = r_up ? r_rise : r_fall;
            SEL_OTHER:  mul_a = r_up ? r_fall : r_rise;
            default:    mul_a = r_mag;
        endcase
    end

    assign mul_b = (r_sel == SEL_SAMPLE) ? w_clamp : w_rest;

    // One 16-bit slice of the operand a cycle, most significant first.
    assign a_pad      = PAD_W'(mul_a);
    assign chunk      = a_pad[(NCHUNK - 1 - int'(r_chunk)) * Q +: Q];
    assign part       = chunk * mul_b;
    assign n_acc      = (r_acc << Q) + PROD_W'(part);
    assign mul_res    = n_acc[Q +: AVG_BITS];
    assign last_chunk = (r_chunk == CHUNK_W'(NCHUNK - 1));

    assign sum = {1'b0, r_p_sample} + {1'b0, r_p_same};
    assign den = {1'b0, r_rise} + {1'b0, r_fall};

    assign rem2    = {r_rem, 1'b0};
    assign ge      = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid   = r_out_valid;
    assign o_level   = r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= SEL_SAMPLE;
            r_chunk     <= '0;
            r_div_cnt   <= '0;
        end else begin
            // The emit state decides the output flag on its own.
            if (r_out_valid && i_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_up  <= i_cmd_flags.up;
                        r_mag <= i_cmd_mag;
                        if (i_cmd_flags.seed) begin
                            r_rise  <= i_cmd_flags.up ? i_cmd_mag : '0;
                            r_fall  <= i_cmd_flags.up ? '0 : i_cmd_mag;
                            r_state <= ST_DIV_INIT;
                        end else begin
                            r_sel   <= SEL_SAMPLE;
                            r_chunk <= '0;
                            r_acc   <= '0;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (last_chunk) begin
                        r_chunk <= '0;
                        r_acc   <= '0;
                        case (r_sel)
                            SEL_SAMPLE: begin
                                r_p_sample <= mul_res;
                                r_sel      <= SEL_SAME;
                            end
                            SEL_SAME: begin
                                r_p_same <= mul_res;
                                r_sel    <= SEL_OTHER;
                            end
                            default: begin
                                // The opposite side only decays.
                                if (r_up) begin
                                    r_fall <= mul_res;
                                end else begin
                                    r_rise <= mul_res;
                                end
                                r_sel   <= SEL_SAMPLE;
                                r_state <= ST_SUM;
                            end
                        endcase
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                        r_acc   <= n_acc;
                    end
                end
                ST_SUM: begin
                    if (r_up) begin
                        r_rise <= sum[AVG_BITS] ? {AVG_BITS{1'b1}} : sum[AVG_BITS-1:0];
                    end else begin
                        r_fall <= sum[AVG_BITS] ? {AVG_BITS{1'b1}} : sum[AVG_BITS-1:0];
                    end
                    r_state <= ST_DIV_INIT;
                end
                ST_DIV_INIT: begin
                    r_den     <= den;
                    r_div_cnt <= '0;
                    if (den == '0) begin
                        r_quot  <= rsi_pkg::WEIGHT_ONE;
                        r_state <= ST_EMIT;
                    end else begin
                        // The numerator never exceeds the sum, so the integer
                        // bit is set only when the fall average is zero.
                        if ({1'b0, r_rise} >= den) begin
                            r_quot <= rsi_pkg::LEVEL_W'(1);
                            r_rem  <= '0;
                        end else begin
                            r_quot <= '0;
                            r_rem  <= {1'b0, r_rise};
                        end
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem     <= ge ? rem_sub[AVG_BITS:0] : rem2[AVG_BITS:0];
                    r_quot    <= {r_quot[rsi_pkg::LEVEL_W-2:0], ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCNT_W'(Q - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_quot;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_decay_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_sel == SEL_OTHER && last_chunk) |-> (mul_res <= mul_a))
        else $error("decayed average grew");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_quot <= rsi_pkg::WEIGHT_ONE))
        else $error("strength level above one");

endmodule

/* design/ema_relative_strength_index_top.sv */
// ----------------------------------------------------------------------------
// ema_relative_strength_index_top
// EMA relative strength index over a stream of closing prices.
// ----------------------------------------------------------------------------
// Each input word carries one closing price in tdata and a series-start flag
// in tuser. The first price of a series (and the first after reset) gives no
// output word; every later price gives rise/(rise+fall) as unsigned Q1.16.
// The front takes a price every cycle while its two-entry command queue has
// room; the back handles one command at a time. An averaging command runs
// through the 16x17 multiplier, which works through each of three products
// one 16-bit slice a cycle, and then through the 16-step restoring divider;
// a seeding command goes straight to the divider.
// The user must write the smoothing weight through the configuration channel
// only while the block is idle, which the block does not enforce; values above 65536 act as 65536.
// ----------------------------------------------------------------------------
module ema_relative_strength_index_top #(
    parameter int PRICE_BITS    = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: close_price
    input  logic [((PRICE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: series_start
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: rsi_level
    output logic [rsi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsi_pkg::WEIGHT_W-1:0]      i_cfg_data
);

    localparam int AVG_BITS = rsi_pkg::avg_width(PRICE_BITS, FRACTION_BITS);
    localparam int CMD_W    = rsi_pkg::FLAGS_W + AVG_BITS;

    logic [rsi_pkg::WEIGHT_W-1:0] r_weight;

    logic                         push;
    logic                         full;
    rsi_pkg::t_cmd_flags          front_flags;
    logic [AVG_BITS-1:0]          front_mag;
    logic                         pop;
    logic                         cmd_valid;
    logic [CMD_W-1:0]             cmd_word;
    rsi_pkg::t_cmd_flags          cmd_flags;
    logic [AVG_BITS-1:0]          cmd_mag;
    logic [rsi_pkg::LEVEL_W-1:0]  level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= rsi_pkg::WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            r_weight <= i_cfg_data;
        end
    end

    rsi_front #(
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .AVG_BITS      (AVG_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_price (s_axis_tdata[PRICE_BITS-1:0]),
        .i_start (s_axis_tuser[0]),
        .i_full  (full),
        .o_push  (push),
        .o_flags (front_flags),
        .o_mag   (front_mag)
    );

    rsi_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (rsi_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_flags, front_mag}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_word)
    );

    assign cmd_flags = cmd_word[CMD_W-1 -: rsi_pkg::FLAGS_W];
    assign cmd_mag   = cmd_word[AVG_BITS-1:0];

    rsi_back #(
        .AVG_BITS (AVG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_weight    (r_weight),
        .i_cmd_valid (cmd_valid),
        .i_cmd_flags (cmd_flags),
        .i_cmd_mag   (cmd_mag),
        .o_cmd_pop   (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_level     (level)
    );

    assign m_axis_tdata = rsi_pkg::OUT_TDATA_W'(level);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the EMA relative strength index.
// ----------------------------------------------------------------------------
// A clocked driver streams closing prices from a queue of pending words that
// the initial block fills. Smoothing-weight writes and drain points sit in the
// same queue. Every accepted price runs through a bench-side model of the
// averages and the divider. The model's levels wait in a queue, and a clocked
// monitor checks each output word against the oldest of them. Both sides
// stall at random, in three idling regimes, and a cycle counter bounds the run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PRICE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int AVG_W       = PRICE_W + FRAC_W;
    localparam logic [63:0] AVG_MAX = (64'd1 << AVG_W) - 64'd1;
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 160;
    localparam int REPORT_MAX  = 10;

    typedef enum logic [1:0] {OP_PRICE, OP_WEIGHT, OP_DRAIN} t_op;
    typedef enum logic [1:0] {POS_EMPTY, POS_PRIMED, POS_RUNNING} t_series_pos;

    typedef struct {
        t_op                          op;
        logic [PRICE_W-1:0]           price;
        logic                         start;
        logic [rsi_pkg::WEIGHT_W-1:0] weight;
        int                           send_idle;
        int                           recv_idle;
    } t_word;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic [PRICE_W-1:0]               s_axis_tdata = '0;
    logic [0:0]                       s_axis_tuser = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rsi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [rsi_pkg::WEIGHT_W-1:0]     i_cfg_data = '0;

    t_word                            pending_words[$];
    logic [rsi_pkg::LEVEL_W-1:0]      rsi_expected[$];

    // Bench-side copy of the block's state and register.
    logic [rsi_pkg::WEIGHT_W-1:0]     smooth_weight;
    logic [PRICE_W-1:0]               last_close;
    logic [63:0]                      rise_avg;
    logic [63:0]                      fall_avg;
    t_series_pos                      series_pos;

    t_word                            cur;
    logic                             have_cur = 1'b0;
    int                               settle_cnt = 0;
    int                               recv_idle_pct = 49;
    logic                             stim_done = 1'b0;
    int                               mismatch_count = 0;
    int                               cycle_count = 0;

    int                               fill_send_idle;
    int                               fill_recv_idle;

    ema_relative_strength_index_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // floor(a * b / 2^16), with each half of a scaled on its own.
    function automatic logic [63:0] scale_q16(input logic [63:0] a, input logic [63:0] b);
        return (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
    endfunction

    function automatic logic [63:0] blend_average(input logic [63:0] old_avg,
                                                  input logic [63:0] sample,
                                                  input logic [63:0] w);
        logic [63:0] v;
        v = scale_q16(sample, w) + scale_q16(old_avg, 64'(rsi_pkg::WEIGHT_ONE) - w);
        return (v > AVG_MAX) ? AVG_MAX : v;
    endfunction

    // Restoring divide of rise by rise+fall, one integer and 16 fraction bits.
    function automatic logic [rsi_pkg::LEVEL_W-1:0] strength_ratio(input logic [63:0] num,
                                                                   input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = '0;
        if (den == 0)
            return rsi_pkg::WEIGHT_ONE;
        if (rem >= den) begin
            q   = 64'd1;
            rem = rem - den;
        end
        for (int k = 0; k < rsi_pkg::Q_BITS; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q[rsi_pkg::LEVEL_W-1:0];
    endfunction

    task automatic predict_level(input logic [PRICE_W-1:0] price, input logic start);
        logic [63:0] w;
        logic [63:0] mag;
        logic        up;
        w = (smooth_weight > rsi_pkg::WEIGHT_ONE) ? 64'(rsi_pkg::WEIGHT_ONE)
                                                  : 64'(smooth_weight);
        if (start || series_pos == POS_EMPTY) begin
            last_close = price;
            rise_avg   = '0;
            fall_avg   = '0;
            series_pos = POS_PRIMED;
            return;
        end
        up  = price > last_close;
        mag = 64'(up ? price - last_close : last_close - price) << FRAC_W;
        if (mag > AVG_MAX)
            mag = AVG_MAX;
        last_close = price;
        if (series_pos == POS_PRIMED) begin
            rise_avg   = up ? mag : 64'd0;
            fall_avg   = up ? 64'd0 : mag;
            series_pos = POS_RUNNING;
        end else if (up) begin
            rise_avg = blend_average(rise_avg, mag, w);
            fall_avg = scale_q16(fall_avg, 64'(rsi_pkg::WEIGHT_ONE) - w);
        end else begin
            rise_avg = scale_q16(rise_avg, 64'(rsi_pkg::WEIGHT_ONE) - w);
            fall_avg = blend_average(fall_avg, mag, w);
        end
        rsi_expected.insert(rsi_expected.size(),
                            strength_ratio(rise_avg, rise_avg + fall_avg));
    endtask

    task automatic add_price(input logic [PRICE_W-1:0] price, input logic start);
        t_word wd;
        wd           = '{op: OP_PRICE, default: '0};
        wd.price     = price;
        wd.start     = start;
        wd.send_idle = fill_send_idle;
        wd.recv_idle = fill_recv_idle;
        pending_words.insert(pending_words.size(), wd);
    endtask

    task automatic add_control(input t_op op, input logic [rsi_pkg::WEIGHT_W-1:0] weight);
        t_word wd;
        wd           = '{op: OP_PRICE, default: '0};
        wd.op        = op;
        wd.weight    = weight;
        wd.send_idle = fill_send_idle;
        wd.recv_idle = fill_recv_idle;
        pending_words.insert(pending_words.size(), wd);
    endtask

    // Driver: one word at a time; control words wait for the block to go idle.
    always @(posedge i_clk) begin : drive_proc
        logic data_free;
        logic cfg_free;
        logic next_tv;
        logic next_cv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            smooth_weight = rsi_pkg::WEIGHT_RESET;
            last_close    = '0;
            rise_avg      = '0;
            fall_avg      = '0;
            series_pos    = POS_EMPTY;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_level(s_axis_tdata, s_axis_tuser[0]);
            if (i_cfg_valid && o_cfg_ready)
                smooth_weight = i_cfg_data;
            data_free = !s_axis_tvalid || s_axis_tready;
            cfg_free  = !i_cfg_valid || o_cfg_ready;
            if (data_free && cfg_free) begin
                next_tv = 1'b0;
                next_cv = 1'b0;
                if (!have_cur && pending_words.size() > 0) begin
                    cur           = pending_words.pop_front();
                    have_cur      = 1'b1;
                    settle_cnt    = 0;
                    recv_idle_pct <= cur.recv_idle;
                end
                if (have_cur) begin
                    case (cur.op)
                        OP_PRICE: begin
                            if ($urandom_range(99) >= cur.send_idle) begin
                                next_tv = 1'b1;
                                s_axis_tdata <= cur.price;
                                s_axis_tuser <= cur.start;
                                have_cur = 1'b0;
                            end
                        end
                        default: begin
                            // A first price of a series leaves no result to
                            // wait for, so give the back end time to settle.
                            if (rsi_expected.size() != 0) begin
                                settle_cnt = 0;
                            end else if (settle_cnt < SETTLE) begin
                                settle_cnt++;
                            end else begin
                                if (cur.op == OP_WEIGHT) begin
                                    next_cv = 1'b1;
                                    i_cfg_data <= cur.weight;
                                end
                                have_cur = 1'b0;
                            end
                        end
                    endcase
                end
                s_axis_tvalid <= next_tv;
                i_cfg_valid   <= next_cv;
                if (!have_cur && !next_tv && !next_cv && pending_words.size() == 0)
                    stim_done <= 1'b1;
            end
        end
    end

    // Monitor: random back-pressure and an in-order check of every word.
    always @(posedge i_clk) begin : monitor_proc
        logic [rsi_pkg::LEVEL_W-1:0] exp_level;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (rsi_expected.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected output word: got %0d", m_axis_tdata);
                end else begin
                    exp_level = rsi_expected.pop_front();
                    if (m_axis_tdata !== rsi_pkg::OUT_TDATA_W'(exp_level)) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < REPORT_MAX)
                            $display("rsi_level mismatch: expected %0d, got %0d",
                                     exp_level, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus_proc
        logic [PRICE_W-1:0]           walk;
        logic [PRICE_W-1:0]           delta;
        logic [rsi_pkg::WEIGHT_W-1:0] w;
        int                           r;

        fill_send_idle = 18;
        fill_recv_idle = 49;

        // The first price after reset opens a series even with the flag clear.
        add_price(32'd100, 1'b0);
        add_price(32'd100, 1'b0);          // flat seed: zero sum gives one
        add_price(32'hFFFF_FFFF, 1'b0);
        add_price(32'd0, 1'b0);
        add_price(32'd0, 1'b0);
        add_price(32'hAAAA_AAAA, 1'b1);
        add_price(32'h5555_5555, 1'b1);    // two series starts back to back
        add_price(32'hAAAA_AAAA, 1'b0);
        add_price(32'hAAAA_AAAB, 1'b0);
        add_control(OP_WEIGHT, rsi_pkg::WEIGHT_ONE);
        add_price(32'd7, 1'b1);
        add_price(32'd1000, 1'b0);
        add_price(32'd3, 1'b0);
        add_price(32'd3, 1'b0);
        add_control(OP_WEIGHT, {rsi_pkg::WEIGHT_W{1'b1}});   // above one, clamps
        add_price(32'd10, 1'b1);
        add_price(32'd20, 1'b0);
        add_price(32'd5, 1'b0);
        add_control(OP_WEIGHT, '0);                 // averages only hold
        add_price(32'd0, 1'b1);
        add_price(32'hFFFF_FFFF, 1'b0);
        add_price(32'hFFFF_FFFE, 1'b0);
        add_price(32'hFFFF_FFFF, 1'b0);
        add_control(OP_WEIGHT, 17'd1);
        add_price(32'd1, 1'b1);
        add_price(32'd2, 1'b0);
        add_price(32'd1, 1'b0);

        walk = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            fill_send_idle = (p < 3) ? 18 : ((p < 6) ? 49 : 0);
            fill_recv_idle = (p < 3) ? 49 : ((p < 6) ? 18 : 0);
            case (p)
                0:       w = rsi_pkg::WEIGHT_RESET;
                1:       w = 17'd2;
                5:       w = rsi_pkg::WEIGHT_W'($urandom_range(65537, 131071));
                8:       w = rsi_pkg::WEIGHT_ONE;
                default: w = rsi_pkg::WEIGHT_W'($urandom_range(1, 65536));
            endcase
            add_control(OP_WEIGHT, w);
            add_price($urandom, 1'b1);
            for (int n = 1; n < PHASE_WORDS; n++) begin
                if ((p == 1 || p == 4) && n == PHASE_WORDS / 2)
                    add_control(OP_DRAIN, '0);
                r = $urandom_range(99);
                if (r < 5) begin
                    walk = $urandom;
                    add_price(walk, 1'b1);
                end else begin
                    if (r < 15) begin
                        walk = $urandom;
                    end else if (r >= 25) begin
                        delta = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1000);
                        walk  = $urandom_range(1) ? walk + delta : walk - delta;
                    end
                    add_price(walk, 1'b0);
                end
            end
        end

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done) @(posedge i_clk);
        while (rsi_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && rsi_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rsi_pkg.sv
design/rsi_front.sv
design/rsi_cmd_fifo.sv
design/rsi_back.sv
design/ema_relative_strength_index_top.sv
tb/testbench.sv
